// ===== hdl/fnvcfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the FNV-checked frame decoder.
// No dependencies; imported by every module of the block.
package fnvcfd_pkg;

   localparam int DEFAULT_POSITION_BITS = 24;
   localparam int LEN_WIDTH             = 24;
   localparam int CSR_INDEX_BITS        = 1;
   localparam int CSR_DATA_WIDTH        = 32;

   localparam int HDR_BYTES      = 13;
   localparam int POS_MAGIC_END  = 3;
   localparam int POS_LENGTH_END = 7;
   localparam int POS_TYPE       = 8;
   localparam int POS_CHECK_END  = 12;
   localparam int TYPE_MAX       = 8;

   localparam logic [LEN_WIDTH-1:0] MAX_LEN_RESET = 24'd65535;

   // Low halves of the 64-bit FNV basis and prime; the low 32 bits of the
   // 64-bit hash depend only on the low 32 bits of its operands.
   localparam logic [31:0] FNV_BASIS_LOW = 32'h8422_2325;
   localparam logic [31:0] FNV_PRIME_LOW = 32'h0000_01b3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGIC_WORD       = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FRAME_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      ST_IN_PROGRESS    = 3'd0,
      ST_OK             = 3'd1,
      ST_BAD_MAGIC      = 3'd2,
      ST_BAD_LENGTH     = 3'd3,
      ST_BAD_TYPE       = 3'd4,
      ST_CHECK_MISMATCH = 3'd5
   } frame_status_type;

   typedef struct packed {
      logic [7:0] stream_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]           payload_byte;
      logic                 has_payload;
      frame_status_type     frame_status;
      logic                 end_of_frame;
      logic [3:0]           message_type;
      logic [LEN_WIDTH-1:0] frame_length;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } result_type;

endpackage

// ===== hdl/fnvcfd_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload per beat.
// Payload type is a parameter; the block uses types from fnvcfd_pkg.
interface fnvcfd_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/fnvcfd_parser.sv =====
`timescale 1ns / 1ps
// Frame parser: header fields, limit checks and FNV-1a hash, one byte a beat.
// Depends on fnvcfd_pkg; produces at most one result per accepted byte.
module fnvcfd_parser #(
   parameter int POSITION_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [7:0]                           stream_byte,
   input  logic [31:0]                          magic_word,
   input  logic [fnvcfd_pkg::LEN_WIDTH-1:0]     max_frame_length,
   output fnvcfd_pkg::result_type               result
);
   import fnvcfd_pkg::*;

   localparam int CMP_WIDTH = ((POSITION_BITS > LEN_WIDTH) ? POSITION_BITS : LEN_WIDTH) + 1;
   localparam logic [32:0] POS_MAX = (33'd1 << POSITION_BITS) - 33'd1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [31:0]              word_ff, word_in;
   logic [LEN_WIDTH-1:0]     exp_len_ff, exp_len_in;
   logic [3:0]               kept_type_ff, kept_type_in;
   logic [31:0]              check_ff, check_in;
   logic [31:0]              hash_ff, hash_in;

   logic [31:0]              word_next;
   logic [31:0]              hash_next;
   logic [POSITION_BITS:0]   pos_inc;
   logic                     in_header;
   logic                     len_bad;
   logic                     type_bad;
   logic                     last_byte;
   logic                     restart;

   assign in_header = pos_ff < POSITION_BITS'(HDR_BYTES);
   assign word_next = {stream_byte, word_ff[31:8]};
   assign hash_next = (hash_ff ^ {24'd0, stream_byte}) * FNV_PRIME_LOW;
   assign pos_inc   = {1'b0, pos_ff} + (POSITION_BITS+1)'(1);
   assign len_bad   = (word_next < 32'(HDR_BYTES))
                   || (word_next > {{(32-LEN_WIDTH){1'b0}}, max_frame_length})
                   || ({1'b0, word_next} > POS_MAX);
   assign type_bad  = (stream_byte == 8'd0) || (stream_byte > 8'(TYPE_MAX));
   assign last_byte = CMP_WIDTH'(pos_inc) >= CMP_WIDTH'(exp_len_ff);

   always_comb begin
      pos_in       = pos_ff;
      word_in      = word_ff;
      exp_len_in   = exp_len_ff;
      kept_type_in = kept_type_ff;
      check_in     = check_ff;
      hash_in      = hash_ff;
      restart      = 1'b0;
      result       = '0;
      if (accept) begin
         pos_in = pos_inc[POSITION_BITS-1:0];
         if (in_header) begin
            word_in = word_next;
            case (pos_ff)
               POSITION_BITS'(POS_MAGIC_END): begin
                  if (word_next != magic_word) begin
                     result.valid             = 1'b1;
                     result.data.frame_status = ST_BAD_MAGIC;
                     restart                  = 1'b1;
                  end
               end
               POSITION_BITS'(POS_LENGTH_END): begin
                  if (len_bad) begin
                     result.valid             = 1'b1;
                     result.data.frame_status = ST_BAD_LENGTH;
                     restart                  = 1'b1;
                  end
                  exp_len_in = word_next[LEN_WIDTH-1:0];
               end
               POSITION_BITS'(POS_TYPE): begin
                  if (type_bad) begin
                     result.valid             = 1'b1;
                     result.data.frame_status = ST_BAD_TYPE;
                     restart                  = 1'b1;
                  end
                  kept_type_in = stream_byte[3:0];
               end
               POSITION_BITS'(POS_CHECK_END): begin
                  check_in = word_next;
                  // header-only frame: hash is still the basis
                  if (exp_len_ff == LEN_WIDTH'(HDR_BYTES)) begin
                     result.valid             = 1'b1;
                     result.data.frame_status = (hash_ff == word_next) ? ST_OK
                                                                       : ST_CHECK_MISMATCH;
                     result.data.message_type = kept_type_ff;
                     restart                  = 1'b1;
                  end
               end
               default: ;
            endcase
            if (restart) begin
               result.data.end_of_frame = 1'b1;
               result.data.frame_length = LEN_WIDTH'(pos_inc);
            end
         end else begin
            hash_in                  = hash_next;
            result.valid             = 1'b1;
            result.data.payload_byte = stream_byte;
            result.data.has_payload  = 1'b1;
            if (last_byte) begin
               result.data.frame_status = (hash_next == check_ff) ? ST_OK : ST_CHECK_MISMATCH;
               result.data.end_of_frame = 1'b1;
               result.data.message_type = kept_type_ff;
               result.data.frame_length = exp_len_ff;
               restart                  = 1'b1;
            end
         end
         // drop the frame state after an end or an error
         if (restart) begin
            pos_in       = '0;
            word_in      = '0;
            exp_len_in   = '0;
            kept_type_in = '0;
            check_in     = '0;
            hash_in      = FNV_BASIS_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         word_ff      <= '0;
         exp_len_ff   <= '0;
         kept_type_ff <= '0;
         check_ff     <= '0;
         hash_ff      <= FNV_BASIS_LOW;
      end else begin
         pos_ff       <= pos_in;
         word_ff      <= word_in;
         exp_len_ff   <= exp_len_in;
         kept_type_ff <= kept_type_in;
         check_ff     <= check_in;
         hash_ff      <= hash_in;
      end
   end

endmodule

// ===== hdl/fnvcfd_out_reg.sv =====
`timescale 1ns / 1ps
// Two-entry output register (main plus skid) for result beats.
// Depends on fnvcfd_pkg; ready towards the parser is registered.
module fnvcfd_out_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  fnvcfd_pkg::result_type           result,
   output logic                             can_take,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output fnvcfd_pkg::rsp_payload_type      rsp_payload
);
   import fnvcfd_pkg::*;

   logic            main_valid_ff, skid_valid_ff;
   rsp_payload_type main_ff, skid_ff;
   logic            pop;

   assign pop         = main_valid_ff && rsp_ready;
   assign can_take    = !skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (result.valid) begin
            main_ff <= result.data;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end else if (result.valid) begin
         // main if empty, else park the beat in skid while main waits
         if (!main_valid_ff) begin
            main_ff       <= result.data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result.data;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

// ===== hdl/fnv_checked_frame_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the FNV-1a checked frame decoder: registers, parser, output stage.
// Depends on fnvcfd_pkg, fnvcfd_stream_if, fnvcfd_parser and fnvcfd_out_reg.
//
//   channel   direction  beat carries
//   req_chan  in         one stream byte
//   rsp_chan  out        payload byte, status, end flag, type, length
//   csr_*     in         register write: index, 32-bit data
//
// One byte is taken every cycle while req_chan.ready is high; parser state and
// the output stage update at the same edge, and the result is registered there.
// The hash step is one constant multiply on the low 32 bits of the hash.
// Reset is synchronous and clears the frame state and both output entries.
// A two-entry output stage keeps req_chan.ready high while one result waits;
// ready drops only when both entries are full.
module fnv_checked_frame_decoder #(
   parameter int POSITION_BITS = fnvcfd_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   fnvcfd_stream_if.sink                             req_chan,
   fnvcfd_stream_if.source                           rsp_chan,
   input  logic                                      csr_write_enable,
   input  logic [fnvcfd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [fnvcfd_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import fnvcfd_pkg::*;

   logic [31:0]          magic_word_ff;
   logic [LEN_WIDTH-1:0] max_len_ff;
   logic                 can_take;
   logic                 accept;
   result_type           result;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= '0;
         max_len_ff    <= MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAGIC_WORD:       magic_word_ff <= csr_write_data[31:0];
            CSR_MAX_FRAME_LENGTH: max_len_ff    <= csr_write_data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   fnvcfd_parser #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .stream_byte      (req_chan.payload.stream_byte),
      .magic_word       (magic_word_ff),
      .max_frame_length (max_len_ff),
      .result           (result)
   );

   fnvcfd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .can_take    (can_take),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

   // a beat without end of frame is always a payload byte in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.end_of_frame
      |-> rsp_chan.payload.has_payload && rsp_chan.payload.frame_status == ST_IN_PROGRESS)
      else $error("non-final result is not an in-progress payload beat");

   // a completed frame carries a legal type and at least a whole header
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.frame_status == ST_OK
                      || rsp_chan.payload.frame_status == ST_CHECK_MISMATCH)
      |-> rsp_chan.payload.end_of_frame
       && rsp_chan.payload.message_type != 4'd0
       && rsp_chan.payload.message_type <= 4'(TYPE_MAX)
       && rsp_chan.payload.frame_length >= LEN_WIDTH'(HDR_BYTES))
      else $error("completed frame with bad type or short length");

   // a bad magic is always found after exactly four header bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.frame_status == ST_BAD_MAGIC
      |-> rsp_chan.payload.frame_length == LEN_WIDTH'(POS_MAGIC_END + 1)
       && !rsp_chan.payload.has_payload)
      else $error("bad magic reported at the wrong place");

   // a full output stage must hold off the input
   assert property (@(posedge clock) disable iff (reset)
      !can_take |-> !accept)
      else $error("byte accepted while output stage is full");

endmodule
